/* rtl/csa_pkg.sv */
// Shared types, constants and helper functions of the coordinated stepper axes.
// Used by csa_lane and by the top level coordinated_stepper_axes.
package csa_pkg;

    localparam int AXIS_COUNT    = 6;
    localparam int POSITION_BITS = 12;
    localparam int GOAL_BITS     = 12;
    localparam int SPEED_BITS    = 8;
    localparam int SPR_BITS      = 10;
    localparam int COUNT_BITS    = 16;
    localparam int COIL_BITS     = 4;
    localparam int ELBOW_AXIS    = 2;
    localparam int GRIPPER_AXIS  = 5;

    localparam logic [COUNT_BITS-1:0] FULL_SCALE     = 16'd60000;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX      = 16'hFFFF;
    localparam logic [COUNT_BITS-1:0] INTERVAL_RESET = 16'd10;

    // Configuration register indexes.
    localparam logic [1:0] REG_MAX_SPEED     = 2'd0;
    localparam logic [1:0] REG_STEPS_PER_REV = 2'd1;
    localparam logic [1:0] REG_TWO_WIRE_MASK = 2'd2;
    localparam logic [1:0] REG_COUPLE_ENABLE = 2'd3;

    typedef struct packed {
        logic load_goal;
        logic start_div;
        logic div_mode;   // 0: speed division, 1: interval division
        logic apply;
        logic motion;
    } lane_ctl_t;

    typedef struct packed {
        logic off;
        logic done;
        logic step;
        logic fwd;
        logic back;
    } lane_stat_t;

    function automatic logic [SPR_BITS-1:0] move_phase(
        input logic [SPR_BITS-1:0] p,
        input logic                fwd,
        input logic                back,
        input logic [SPR_BITS-1:0] m
    );
        logic [SPR_BITS:0] inc;
        logic [SPR_BITS-1:0] r;
        inc = {1'b0, p} + {{SPR_BITS{1'b0}}, 1'b1};
        r = p;
        if (fwd)
        begin
            r = (inc >= {1'b0, m}) ? '0 : inc[SPR_BITS-1:0];
        end
        else if (back)
        begin
            r = (p == '0 || p >= m) ? m - 1'b1 : p - 1'b1;
        end
        return r;
    endfunction

    function automatic logic [COIL_BITS-1:0] coil_pattern(
        input logic [1:0] p,
        input logic       two_wire
    );
        logic [COIL_BITS-1:0] r;
        unique case (p)
            2'd0: r = two_wire ? 4'd2 : 4'd5;
            2'd1: r = two_wire ? 4'd3 : 4'd6;
            2'd2: r = two_wire ? 4'd1 : 4'd10;
            default: r = two_wire ? 4'd0 : 4'd9;
        endcase
        return r;
    endfunction

endpackage

/* rtl/coordinated_stepper_axes.sv */
// Top level of the coordinated stepper axes: six axis lanes, a shared base
// divider, the merge of the lanes' errors and the output register.
// Depends on csa_pkg, csa_div and csa_lane.
//
// Every input transfer yields exactly one result transfer. A goal command
// (tuser = 1) loads the six goals and goes straight to the result stage. A
// tick while idle updates the lanes and then reaches the result stage. A tick
// during motion runs two back-to-back serial divisions in all six lanes at
// once (speed = max_speed*|error|/|largest|, then interval = (60000 /
// steps_per_rev) / speed), each one quotient bit per cycle. The block takes
// the next transfer only after the previous result is in the output register;
// that register holds the result while the downstream side stalls.
module coordinated_stepper_axes
    import csa_pkg::*;
#(
    parameter int PB = POSITION_BITS
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // goal_base[11:0], goal_shoulder, goal_elbow, goal_wrist_right,
    // goal_wrist_left, goal_gripper[71:60]
    input  logic [71:0]           s_tdata,
    // command: 0 = one millisecond tick, 1 = load goals
    input  logic                  s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // coils_base[3:0] .. coils_gripper[23:20], in_motion[24], arrived[25]
    output logic [31:0]           m_tdata,
    input  logic                  cfg_we,
    input  logic [1:0]            cfg_addr,
    input  logic [SPR_BITS-1:0]   cfg_data
);
    localparam int AW = PB + 1;
    localparam int NW = SPEED_BITS + AW;
    localparam int DW = (AW > SPR_BITS) ? AW : SPR_BITS;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_START = 6'b000010,
        S_DIV1  = 6'b000100,
        S_SPEED = 6'b001000,
        S_DIV2  = 6'b010000,
        S_FIN   = 6'b100000
    } state_t;

    localparam state_t S_APPLY_UNUSED = S_FIN;

    state_t state_reg, state_next;
    logic                  apply_reg, apply_next;
    logic [SPEED_BITS-1:0] max_speed_reg;
    logic [SPR_BITS-1:0]   spr_reg;
    logic [AXIS_COUNT-1:0] two_wire_reg;
    logic                  couple_reg;
    logic                  motion_reg, motion_next;
    logic                  was_moving_reg, was_moving_next;
    logic                  is_tick_reg, is_tick_next;
    logic [AW-1:0]         largest_reg, largest_next;
    logic [COUNT_BITS-1:0] base_reg;
    logic                  out_valid_reg, out_valid_next;
    logic [31:0]           out_data_reg, out_data_next;

    logic                  accept;
    logic [SPR_BITS-1:0]   modulus;
    lane_ctl_t             ctl;
    lane_stat_t            stat [AXIS_COUNT];
    logic [AW-1:0]         abs_err [AXIS_COUNT];
    logic [COIL_BITS-1:0]  coils [AXIS_COUNT];
    logic [NW-1:0]         base_quo;
    logic                  base_done;
    logic                  any_off;
    logic                  couple_ev;

    assign modulus  = (spr_reg == '0) ? SPR_BITS'(1) : spr_reg;
    assign s_tready = (state_reg == S_IDLE) && !apply_reg;
    assign accept   = s_tvalid && s_tready;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_speed_reg <= SPEED_BITS'(65);
            spr_reg       <= SPR_BITS'(100);
            two_wire_reg  <= '0;
            couple_reg    <= 1'b1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_MAX_SPEED:     max_speed_reg <= cfg_data[SPEED_BITS-1:0];
                REG_STEPS_PER_REV: spr_reg       <= cfg_data;
                REG_TWO_WIRE_MASK: two_wire_reg  <= cfg_data[AXIS_COUNT-1:0];
                default:           couple_reg    <= cfg_data[0];
            endcase
        end
    end

    // Lane control. The apply cycle is a flag beside the state so that an idle
    // tick can go straight from the idle state to the update.
    assign ctl.load_goal = accept && s_tuser;
    assign ctl.start_div = (state_reg == S_START) || (state_reg == S_SPEED);
    assign ctl.div_mode  = (state_reg == S_SPEED);
    assign ctl.apply     = apply_reg;
    assign ctl.motion    = motion_reg;

    // The elbow step re-drives the gripper and moves its phase the other way.
    assign couple_ev = couple_reg && stat[ELBOW_AXIS].step;

    for (genvar i = 0; i < AXIS_COUNT; i++)
    begin : g_lane
        logic cpl, cpl_fwd, cpl_back;
        assign cpl      = (i == GRIPPER_AXIS) ? couple_ev : 1'b0;
        assign cpl_fwd  = (i == GRIPPER_AXIS) ? stat[ELBOW_AXIS].back : 1'b0;
        assign cpl_back = (i == GRIPPER_AXIS) ? stat[ELBOW_AXIS].fwd : 1'b0;

        csa_lane #(.PB(PB)) u_lane (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctl         (ctl),
            .goal        (s_tdata[GOAL_BITS*i +: GOAL_BITS]),
            .largest     (largest_reg),
            .base        (base_reg),
            .max_speed   (max_speed_reg),
            .modulus     (modulus),
            .two_wire    (two_wire_reg[i]),
            .couple      (cpl),
            .couple_fwd  (cpl_fwd),
            .couple_back (cpl_back),
            .abs_err     (abs_err[i]),
            .stat        (stat[i]),
            .coils       (coils[i])
        );
    end

    // 60000 / steps_per_rev runs alongside the lanes' speed division.
    csa_div #(.NW(NW), .DW(DW)) u_base_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (state_reg == S_START),
        .num   (NW'(FULL_SCALE)),
        .den   (DW'(modulus)),
        .quo   (base_quo),
        .done  (base_done)
    );

    always_ff @(posedge clk)
    begin
        if (base_done)
        begin
            base_reg <= base_quo[COUNT_BITS-1:0];
        end
    end

    // Merge stage: largest error and whether any axis is still off target.
    always_comb
    begin
        largest_next = '0;
        any_off      = 1'b0;
        for (int i = 0; i < AXIS_COUNT; i++)
        begin
            if (abs_err[i] > largest_next)
            begin
                largest_next = abs_err[i];
            end
            any_off = any_off | stat[i].off;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        apply_next      = 1'b0;
        motion_next     = motion_reg;
        was_moving_next = was_moving_reg;
        is_tick_next    = is_tick_reg;
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (apply_reg)
        begin
            state_next = S_FIN;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        is_tick_next    = !s_tuser;
                        was_moving_next = motion_reg;
                        if (s_tuser)
                        begin
                            state_next = S_FIN;
                        end
                        else if (motion_reg)
                        begin
                            state_next = S_START;
                        end
                        else
                        begin
                            apply_next = 1'b1;
                        end
                    end
                end
                S_START: state_next = S_DIV1;
                S_DIV1:
                begin
                    if (base_done)
                    begin
                        state_next = S_SPEED;
                    end
                end
                S_SPEED: state_next = S_DIV2;
                S_DIV2:
                begin
                    if (stat[0].done)
                    begin
                        state_next = S_IDLE;
                        apply_next = 1'b1;
                    end
                end
                default:
                begin
                    if (!out_valid_reg || m_tready)
                    begin
                        motion_next    = any_off;
                        out_valid_next = 1'b1;
                        out_data_next  = {6'd0,
                                          is_tick_reg && was_moving_reg && !any_off,
                                          any_off,
                                          coils[5], coils[4], coils[3],
                                          coils[2], coils[1], coils[0]};
                        state_next     = S_IDLE;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            apply_reg      <= 1'b0;
            motion_reg     <= 1'b0;
            was_moving_reg <= 1'b0;
            is_tick_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            apply_reg      <= apply_next;
            motion_reg     <= motion_next;
            was_moving_reg <= was_moving_next;
            is_tick_reg    <= is_tick_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        if (accept && !s_tuser && motion_reg)
        begin
            largest_reg <= largest_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

`ifndef ASSERT_OFF
    a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("state register not one-hot");

    a_arrived_idle: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tdata[25] && m_tdata[24]))
        else $error("arrived reported while still in motion");

    a_div2_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV2) |-> ($past(state_reg) == S_SPEED || $past(state_reg) == S_DIV2))
        else $error("interval division entered out of order");

    a_apply_fin: assert property (@(posedge clk) disable iff (!rst_n)
        apply_reg |=> (state_reg == S_APPLY_UNUSED))
        else $error("update cycle not followed by result stage");
`endif

endmodule

/* rtl/csa_div.sv */
// Restoring unsigned divider, one quotient bit per cycle.
// Stand-alone; used by csa_lane and the top level.
module csa_div #(
    parameter int NW = 21,
    parameter int DW = 13
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic [NW-1:0] quo,
    output logic          done
);
    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0] quo_reg, quo_next;
    logic [DW:0]   rem_reg, rem_next;
    logic [DW-1:0] den_reg, den_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [DW:0]   rem_sh;

    assign rem_sh = {rem_reg[DW-1:0], quo_reg[NW-1]};

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            quo_next  = num;
            rem_next  = '0;
            den_next  = den;
            cnt_next  = CW'(NW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (rem_sh >= {1'b0, den_reg})
            begin
                rem_next = rem_sh - {1'b0, den_reg};
                quo_next = {quo_reg[NW-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh;
                quo_next = {quo_reg[NW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign quo  = quo_reg;
    assign done = done_reg;

endmodule

/* rtl/csa_lane.sv */
// One axis lane: goal, position, phase, tick count, step interval and coils.
// Depends on csa_pkg and csa_div.
module csa_lane
    import csa_pkg::*;
#(
    parameter int PB = POSITION_BITS
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  lane_ctl_t             ctl,
    input  logic [GOAL_BITS-1:0]  goal,
    input  logic [PB:0]           largest,
    input  logic [COUNT_BITS-1:0] base,
    input  logic [SPEED_BITS-1:0] max_speed,
    input  logic [SPR_BITS-1:0]   modulus,
    input  logic                  two_wire,
    input  logic                  couple,
    input  logic                  couple_fwd,
    input  logic                  couple_back,
    output logic [PB:0]           abs_err,
    output lane_stat_t            stat,
    output logic [COIL_BITS-1:0]  coils
);
    localparam int AW = PB + 1;
    localparam int NW = SPEED_BITS + AW;
    localparam int DW = (AW > SPR_BITS) ? AW : SPR_BITS;

    logic [PB-1:0]         target_reg, target_next;
    logic [PB-1:0]         cur_reg, cur_next;
    logic [SPR_BITS-1:0]   phase_reg, phase_next;
    logic [COUNT_BITS-1:0] ticks_reg, ticks_next;
    logic [COUNT_BITS-1:0] interval_reg, interval_next;
    logic [COIL_BITS-1:0]  coil_reg, coil_next;
    logic [SPEED_BITS-1:0] speed_reg, speed_next;
    logic                  mode_reg, mode_next;

    logic [AW-1:0]         err;
    logic                  neg, off;
    logic [NW-1:0]         div_num, div_quo;
    logic [DW-1:0]         div_den;
    logic                  div_done;
    logic [COUNT_BITS-1:0] t1;
    logic                  step, fwd, back;
    logic [SPR_BITS-1:0]   p1, p2;
    logic signed [GOAL_BITS-1:0] goal_s;

    assign goal_s  = goal;
    assign err     = {target_reg[PB-1], target_reg} - {cur_reg[PB-1], cur_reg};
    assign neg     = err[AW-1];
    assign off     = (err != '0);
    assign abs_err = neg ? (~err + 1'b1) : err;

    assign div_num = ctl.div_mode ? NW'(base) : NW'(max_speed) * NW'(abs_err);
    assign div_den = ctl.div_mode ? DW'(speed_reg) : DW'(largest);

    csa_div #(.NW(NW), .DW(DW)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (ctl.start_div),
        .num   (div_num),
        .den   (div_den),
        .quo   (div_quo),
        .done  (div_done)
    );

    assign t1   = (ticks_reg == COUNT_MAX) ? ticks_reg : ticks_reg + 1'b1;
    assign step = ctl.apply && ctl.motion && (t1 >= interval_reg);
    assign fwd  = step && off && !neg;
    assign back = step && neg;
    assign p1   = couple ? move_phase(phase_reg, couple_fwd, couple_back, modulus) : phase_reg;
    assign p2   = step ? move_phase(p1, fwd, back, modulus) : p1;

    always_comb
    begin
        target_next   = target_reg;
        cur_next      = cur_reg;
        phase_next    = phase_reg;
        ticks_next    = ticks_reg;
        interval_next = interval_reg;
        coil_next     = coil_reg;
        speed_next    = speed_reg;
        mode_next     = mode_reg;
        if (ctl.load_goal)
        begin
            target_next = PB'(goal_s);
        end
        if (ctl.start_div)
        begin
            mode_next = ctl.div_mode;
        end
        if (div_done)
        begin
            if (!mode_reg)
            begin
                speed_next = (div_quo[SPEED_BITS-1:0] == '0) ? SPEED_BITS'(1)
                                                             : div_quo[SPEED_BITS-1:0];
            end
            else if (off)
            begin
                interval_next = div_quo[COUNT_BITS-1:0];
            end
        end
        if (ctl.apply)
        begin
            ticks_next = step ? '0 : t1;
            phase_next = p2;
            if (fwd)
            begin
                cur_next = cur_reg + 1'b1;
            end
            else if (back)
            begin
                cur_next = cur_reg - 1'b1;
            end
            if (step)
            begin
                coil_next = coil_pattern(p2[1:0], two_wire);
            end
            else if (couple)
            begin
                coil_next = coil_pattern(p1[1:0], two_wire);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg   <= '0;
            cur_reg      <= '0;
            phase_reg    <= '0;
            ticks_reg    <= '0;
            interval_reg <= INTERVAL_RESET;
            coil_reg     <= '0;
            speed_reg    <= SPEED_BITS'(1);
            mode_reg     <= 1'b0;
        end
        else
        begin
            target_reg   <= target_next;
            cur_reg      <= cur_next;
            phase_reg    <= phase_next;
            ticks_reg    <= ticks_next;
            interval_reg <= interval_next;
            coil_reg     <= coil_next;
            speed_reg    <= speed_next;
            mode_reg     <= mode_next;
        end
    end

    assign stat.off  = off;
    assign stat.done = div_done;
    assign stat.step = step;
    assign stat.fwd  = fwd;
    assign stat.back = back;
    assign coils     = coil_reg;

endmodule

/* tb/csa_checker.sv */
`timescale 1ns / 100ps
// Checker for coordinated_stepper_axes: watches the config port and both streams,
// predicts every result transfer and compares it field by field.
// Depends on csa_pkg.
module csa_checker
    import csa_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    input  logic                s_tready,
    input  logic [71:0]         s_tdata,
    input  logic                s_tuser,
    input  logic                m_tvalid,
    input  logic                m_tready,
    input  logic [31:0]         m_tdata,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_addr,
    input  logic [SPR_BITS-1:0] cfg_data,
    output int                  pending,
    output int                  fail_count
);

    localparam int TWO_PIN [4]  = '{2, 3, 1, 0};
    localparam int FOUR_PIN [4] = '{5, 6, 10, 9};

    logic [SPEED_BITS-1:0] speed_max;
    logic [SPR_BITS-1:0]   rev_steps;
    logic [5:0]            two_wire;
    logic                  coupled;

    int                    goal_pos [AXIS_COUNT];
    int                    cur_pos [AXIS_COUNT];
    logic [SPR_BITS-1:0]   phase [AXIS_COUNT];
    int                    tick_cnt [AXIS_COUNT];
    int                    interval [AXIS_COUNT];
    logic [COIL_BITS-1:0]  coils [AXIS_COUNT];
    logic                  moving;

    logic [25:0]           expected_coils_q [$];

    function automatic int rev_mod();
        return (rev_steps == 0) ? 1 : int'(rev_steps);
    endfunction

    function automatic logic off_target();
        for (int i = 0; i < AXIS_COUNT; i++)
            if (cur_pos[i] != goal_pos[i])
                return 1'b1;
        return 1'b0;
    endfunction

    function automatic void step_phase(int ax, int dir);
        int m;
        int p;
        m = rev_mod();
        p = int'(phase[ax]);
        if (dir > 0)
            p = (p + 1 >= m) ? 0 : p + 1;
        else if (dir < 0)
            p = (p == 0 || p >= m) ? m - 1 : p - 1;
        phase[ax] = p[SPR_BITS-1:0];
        coils[ax] = COIL_BITS'(two_wire[ax] ? TWO_PIN[phase[ax][1:0]]
                                            : FOUR_PIN[phase[ax][1:0]]);
    endfunction

    // Advance the axis model by one input transfer and return the packed result.
    function automatic logic [25:0] advance_axes(logic cmd, logic [71:0] goals);
        int   err [AXIS_COUNT];
        int   biggest;
        int   a;
        int   spd;
        int   dir;
        logic was_moving;
        logic done;
        logic [25:0] r;
        done = 1'b0;
        if (cmd)
        begin
            for (int i = 0; i < AXIS_COUNT; i++)
                goal_pos[i] = int'($signed(goals[12*i +: 12]));
            moving = off_target();
        end
        else
        begin
            was_moving = moving;
            for (int i = 0; i < AXIS_COUNT; i++)
                if (tick_cnt[i] < 65535)
                    tick_cnt[i]++;
            if (moving)
            begin
                biggest = 0;
                for (int i = 0; i < AXIS_COUNT; i++)
                begin
                    err[i] = goal_pos[i] - cur_pos[i];
                    a = (err[i] < 0) ? -err[i] : err[i];
                    if (a > biggest)
                        biggest = a;
                end
                for (int i = 0; i < AXIS_COUNT; i++)
                begin
                    a = (err[i] < 0) ? -err[i] : err[i];
                    if (a != 0 && biggest != 0)
                    begin
                        spd = int'(speed_max) * a / biggest;
                        if (spd == 0)
                            spd = 1;
                        interval[i] = 60000 / rev_mod() / spd;
                    end
                end
                for (int i = 0; i < AXIS_COUNT; i++)
                begin
                    if (tick_cnt[i] < interval[i])
                        continue;
                    tick_cnt[i] = 0;
                    dir = (err[i] > 0) ? 1 : ((err[i] < 0) ? -1 : 0);
                    cur_pos[i] += dir;
                    step_phase(i, dir);
                    // The elbow drags the gripper phase the other way.
                    if (i == ELBOW_AXIS && coupled)
                        step_phase(GRIPPER_AXIS, -dir);
                end
            end
            moving = off_target();
            done = was_moving && !moving;
        end
        for (int i = 0; i < AXIS_COUNT; i++)
            r[4*i +: 4] = coils[i];
        r[24] = moving;
        r[25] = done;
        return r;
    endfunction

    assign pending = expected_coils_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        logic [25:0] exp_r;
        if (!rst_n)
        begin
            speed_max = 8'd65;
            rev_steps = 10'd100;
            two_wire  = '0;
            coupled   = 1'b1;
            for (int i = 0; i < AXIS_COUNT; i++)
            begin
                goal_pos[i] = 0;
                cur_pos[i]  = 0;
                phase[i]    = '0;
                tick_cnt[i] = 0;
                interval[i] = 10;
                coils[i]    = '0;
            end
            moving = 1'b0;
            fail_count = 0;
            expected_coils_q.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_addr)
                    REG_MAX_SPEED:     speed_max = cfg_data[SPEED_BITS-1:0];
                    REG_STEPS_PER_REV: rev_steps = cfg_data;
                    REG_TWO_WIRE_MASK: two_wire  = cfg_data[5:0];
                    default:           coupled   = cfg_data[0];
                endcase
            end
            if (s_tvalid && s_tready)
                expected_coils_q.push_back(advance_axes(s_tuser, s_tdata));
            if (m_tvalid && m_tready)
            begin
                if (expected_coils_q.size() == 0)
                begin
                    $error("unexpected result transfer %h", m_tdata);
                    fail_count++;
                end
                else
                begin
                    exp_r = expected_coils_q.pop_front();
                    for (int i = 0; i < AXIS_COUNT; i++)
                        if (m_tdata[4*i +: 4] !== exp_r[4*i +: 4])
                        begin
                            $error("coils axis %0d: expected %h, actual %h",
                                   i, exp_r[4*i +: 4], m_tdata[4*i +: 4]);
                            fail_count++;
                        end
                    if (m_tdata[24] !== exp_r[24])
                    begin
                        $error("in_motion: expected %b, actual %b", exp_r[24], m_tdata[24]);
                        fail_count++;
                    end
                    if (m_tdata[25] !== exp_r[25])
                    begin
                        $error("arrived: expected %b, actual %b", exp_r[25], m_tdata[25]);
                        fail_count++;
                    end
                end
            end
        end
    end

endmodule

/* tb/coordinated_stepper_axes_tb.sv */
`timescale 1ns / 100ps
// Top of the coordinated_stepper_axes testbench: clock, reset, stimulus and verdict.
// Depends on csa_pkg, the block itself and csa_checker.
module coordinated_stepper_axes_tb;
    import csa_pkg::*;

    localparam int CYCLE_LIMIT = 3000000;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                s_tvalid;
    logic                s_tready;
    logic [71:0]         s_tdata;
    logic                s_tuser;
    logic                m_tvalid;
    logic                m_tready;
    logic [31:0]         m_tdata;
    logic                cfg_we;
    logic [1:0]          cfg_addr;
    logic [SPR_BITS-1:0] cfg_data;
    int                  pending;
    int                  fail_count;
    int                  cycles = 0;

    // Goals last sent, so that new goals can be kept close to them.
    int                  last_goal [AXIS_COUNT];

    coordinated_stepper_axes DUT (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data)
    );

    csa_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data),
        .pending(pending), .fail_count(fail_count)
    );

    always #5 clk = ~clk;

    // A hung handshake ends the run here.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // The receiving side stalls a random number of cycles before each result.
    initial
    begin
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            m_tready = 1'b0;
            repeat ($urandom_range(0, 16)) @(negedge clk);
            m_tready = 1'b1;
            @(posedge clk);
            while (!m_tvalid)
                @(posedge clk);
        end
    end

    // One input transfer after a random gap. The valid line is lowered at the
    // falling edge that follows the transfer.
    task automatic send_item(input logic cmd, input logic [71:0] goals);
        repeat ($urandom_range(0, 16)) @(negedge clk);
        s_tuser  = cmd;
        s_tdata  = goals;
        s_tvalid = 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
        s_tvalid = 1'b0;
        s_tdata  = 72'($urandom());
        s_tuser  = 1'($urandom_range(0, 1));
        if (cmd)
            for (int i = 0; i < AXIS_COUNT; i++)
                last_goal[i] = int'($signed(goals[12*i +: 12]));
    endtask

    task automatic send_goals(input int g0, input int g1, input int g2,
                              input int g3, input int g4, input int g5);
        send_item(1'b1, {g5[11:0], g4[11:0], g3[11:0], g2[11:0], g1[11:0], g0[11:0]});
    endtask

    // Noise on the goal lanes of a tick; they must be ignored.
    task automatic send_tick();
        send_item(1'b0, 72'({$urandom(), $urandom(), $urandom()}));
    endtask

    // Register writes happen only once every result is out and the block is quiet.
    task automatic write_reg(input logic [1:0] idx, input int value);
        while (pending != 0)
            @(negedge clk);
        repeat (60) @(negedge clk);
        cfg_addr = idx;
        cfg_data = value[SPR_BITS-1:0];
        cfg_we   = 1'b1;
        @(negedge clk);
        cfg_we   = 1'b0;
    endtask

    // New goals close to the previous ones, clipped to the signed goal range.
    task automatic send_near_goals(input int reach);
        int g [AXIS_COUNT];
        for (int i = 0; i < AXIS_COUNT; i++)
        begin
            g[i] = last_goal[i] + $urandom_range(0, 2 * reach) - reach;
            if ($urandom_range(0, 3) == 0)
                g[i] = last_goal[i];
            if (g[i] > 2047)
                g[i] = 2047;
            if (g[i] < -2048)
                g[i] = -2048;
        end
        send_goals(g[0], g[1], g[2], g[3], g[4], g[5]);
    endtask

    initial
    begin
        int sent;
        int burst;
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = 1'b0;
        cfg_we   = 1'b0;
        cfg_addr = REG_MAX_SPEED;
        cfg_data = '0;
        for (int i = 0; i < AXIS_COUNT; i++)
            last_goal[i] = 0;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed part. Ticks while idle, then a short move at reset settings.
        send_tick();
        send_tick();
        send_goals(1, -1, 2, 0, 0, -2);
        repeat (4) send_tick();
        // Fastest setting gives a zero interval; extreme goals, then back.
        write_reg(REG_MAX_SPEED, 255);
        write_reg(REG_STEPS_PER_REV, 1023);
        write_reg(REG_TWO_WIRE_MASK, 63);
        send_goals(2047, -2048, 2047, -2048, 2047, -2048);
        repeat (3) send_tick();
        send_goals(0, 0, 0, 0, 0, 0);
        send_goals(0, 0, 0, 0, 0, 0);
        // Zero modulus and zero speed, elbow coupling off.
        write_reg(REG_STEPS_PER_REV, 0);
        write_reg(REG_MAX_SPEED, 0);
        write_reg(REG_COUPLE_ENABLE, 0);
        write_reg(REG_TWO_WIRE_MASK, 0);
        send_goals(3, 1, -3, 0, 2, 0);
        repeat (6) send_tick();

        // Random part: phases of settings, each a run of moves with noise.
        sent = 0;
        while (sent < 2000)
        begin
            write_reg(REG_MAX_SPEED, ($urandom_range(0, 3) == 0) ? 255 : $urandom_range(0, 255));
            write_reg(REG_STEPS_PER_REV,
                      ($urandom_range(0, 3) == 0) ? 1023 : $urandom_range(0, 1023));
            write_reg(REG_TWO_WIRE_MASK, $urandom_range(0, 63));
            write_reg(REG_COUPLE_ENABLE, $urandom_range(0, 1));
            burst = $urandom_range(60, 200);
            for (int k = 0; k < burst; k++)
            begin
                case ($urandom_range(0, 19))
                    0:       send_near_goals(8);
                    1:       send_goals($urandom(), $urandom(), $urandom(),
                                        $urandom(), $urandom(), $urandom());
                    2:       send_near_goals(1);
                    default: send_tick();
                endcase
                sent++;
            end
        end

        while (pending != 0)
            @(negedge clk);
        repeat (100) @(negedge clk);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
